/* hdl/tcprt_pkg.sv */
// ----------------------------------------------------------------------------
// tcprt_pkg: shared types and constants of the TCP timer table
// Payload structs, operation and event codes, register indexes.
// ----------------------------------------------------------------------------
package tcprt_pkg;

	localparam int SLOTS_DEF = 16;

	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_ARM_TW  = 3'd1;
	localparam logic [2:0] OP_ARM_RT  = 3'd2;
	localparam logic [2:0] OP_CANCEL  = 3'd3;
	localparam logic [2:0] OP_WINDOW  = 3'd4;

	localparam logic [1:0] EV_CLOSE  = 2'd0;
	localparam logic [1:0] EV_RESEND = 2'd1;
	localparam logic [1:0] EV_RESET  = 2'd2;

	localparam logic       KIND_TW = 1'b0;
	localparam logic       KIND_RT = 1'b1;

	localparam logic [23:0] TICK_INTERVAL_RST = 24'd100000;
	localparam logic [25:0] TIMEWAIT_TIME_RST = 26'd2000000;
	localparam logic [25:0] RETRANS_BASE_RST  = 26'd200000;
	localparam logic [3:0]  RETRY_LIMIT_RST   = 4'd6;

	typedef enum logic [1:0] {
		REG_TICK_INTERVAL = 2'd0,
		REG_TIMEWAIT_TIME = 2'd1,
		REG_RETRANS_BASE  = 2'd2,
		REG_RETRY_LIMIT   = 2'd3
	} reg_idx_t;

	typedef enum logic {
		ALU_SUB = 1'b0,
		ALU_SHL = 1'b1
	} alu_mode_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [3:0]  slot;
		logic [15:0] window;
	} req_t;

	typedef struct packed {
		logic [3:0]  slot_out;
		logic [1:0]  event_res;
		logic [3:0]  retry_out;
		logic [31:0] next_timeout;
		logic [14:0] threshold;
		logic        last;
	} evt_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [25:0] value;
	} cfg_wr_t;

	typedef struct packed {
		logic [23:0] tick_interval;
		logic [25:0] timewait_time;
		logic [25:0] retrans_base;
		logic [3:0]  retry_limit;
	} cfg_regs_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  retry;
		logic [31:0] remaining;
	} entry_t;

	typedef struct packed {
		logic ent_we;
		logic win_we;
		logic act_set;
		logic act_clr;
	} tbl_ctl_t;

endpackage

/* hdl/tcprt_chan_if.sv */
// ----------------------------------------------------------------------------
// tcprt_chan_if: valid/ready channel
// One beat moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface tcprt_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/tcprt_cfg.sv */
// ----------------------------------------------------------------------------
// tcprt_cfg: configuration registers
// Tick interval, time-wait time, retransmit base and retry limit.
// ----------------------------------------------------------------------------
module tcprt_cfg (
	input  logic                clk,
	input  logic                arst_n,
	tcprt_chan_if.sink          cfg,
	output tcprt_pkg::cfg_regs_t regs
);
	import tcprt_pkg::*;

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.tick_interval <= TICK_INTERVAL_RST;
			regs_q.timewait_time <= TIMEWAIT_TIME_RST;
			regs_q.retrans_base  <= RETRANS_BASE_RST;
			regs_q.retry_limit   <= RETRY_LIMIT_RST;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.data.index))
				REG_TICK_INTERVAL: regs_q.tick_interval <= cfg.data.value[23:0];
				REG_TIMEWAIT_TIME: regs_q.timewait_time <= cfg.data.value;
				REG_RETRANS_BASE:  regs_q.retrans_base  <= cfg.data.value;
				REG_RETRY_LIMIT:   regs_q.retry_limit   <= cfg.data.value[3:0];
				default: ;
			endcase
		end
	end
endmodule

/* hdl/tcprt_alu.sv */
// ----------------------------------------------------------------------------
// tcprt_alu: shared subtract/compare and saturating shift unit
// Subtract mode lowers a timer and flags a > b; shift mode forms backoff.
// ----------------------------------------------------------------------------
module tcprt_alu (
	input  tcprt_pkg::alu_mode_t mode,
	input  logic [31:0]          a,
	input  logic [31:0]          b,
	output logic [31:0]          res,
	output logic                 gt
);
	import tcprt_pkg::*;

	logic [46:0] wide;

	always_comb begin
		wide = {15'd0, a} << b[3:0];
		gt   = a > b;
		case (mode)
			ALU_SUB: res = a - b;
			ALU_SHL: res = (|wide[46:32]) ? 32'hFFFF_FFFF : wide[31:0];
			default: res = a - b;
		endcase
	end
endmodule

/* hdl/tcprt_table.sv */
// ----------------------------------------------------------------------------
// tcprt_table: per-slot timer and window storage
// Entry and window memories with registered read; active and window-set bits.
// ----------------------------------------------------------------------------
module tcprt_table #(
	parameter int SLOTS = tcprt_pkg::SLOTS_DEF,
	parameter int SW    = $clog2(SLOTS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [SW-1:0]         rd_addr,
	input  logic [SW-1:0]         wr_addr,
	input  tcprt_pkg::tbl_ctl_t   ctl,
	input  tcprt_pkg::entry_t     ent_wr,
	input  logic [15:0]           win_wr,
	output tcprt_pkg::entry_t     ent_rd,
	output logic [15:0]           win_rd,
	output logic                  act_rd
);
	import tcprt_pkg::*;

	entry_t            ent_mem [SLOTS];
	logic [15:0]       win_mem [SLOTS];
	logic [SLOTS-1:0]  act_q;
	logic [SLOTS-1:0]  wset_q;
	entry_t            ent_rd_q;
	logic [15:0]       win_rd_q;
	logic              wset_rd_q;

	always_ff @(posedge clk) begin
		if (ctl.ent_we) begin
			ent_mem[wr_addr] <= ent_wr;
		end
		if (ctl.win_we) begin
			win_mem[wr_addr] <= win_wr;
		end
		ent_rd_q  <= ent_mem[rd_addr];
		win_rd_q  <= win_mem[rd_addr];
		wset_rd_q <= wset_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= '0;
			wset_q <= '0;
		end else begin
			if (ctl.act_set) begin
				act_q[wr_addr] <= 1'b1;
			end else if (ctl.act_clr) begin
				act_q[wr_addr] <= 1'b0;
			end
			if (ctl.win_we) begin
				wset_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign ent_rd = ent_rd_q;
	assign win_rd = wset_rd_q ? win_rd_q : 16'd1;
	assign act_rd = act_q[rd_addr];
endmodule

/* hdl/tcp_retransmit_timewait_timer_table.sv */
// ----------------------------------------------------------------------------
// tcp_retransmit_timewait_timer_table: TCP time-wait and retransmit timers
// Per-slot timer table walked slot by slot on each tick through one shared
// subtract/shift unit; expiries report close, resend with backoff, or reset.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          beat when
//  req      in   operation, slot, window                          valid & ready
//  evt      out  slot_out, event_res, retry_out, next_timeout,    valid & ready
//                threshold, last
//  cfg      in   index, value                                     valid & ready
//
//  Arm, cancel and set-window items are written as they are accepted.
//  A tick walks slots 0..SLOTS-1 through one shared unit: an idle slot passes
//  READ, a timer that only counts down READ and EVAL, a close or reset READ,
//  EVAL and EMIT, a resend READ, EVAL, SHIFT and EMIT; FLUSH ends the walk.
//  A held result stalls the walk at the next expiry or at the tick's end.
//  Reset clears all timers and sets every window to 1; req is ready at once.
// ----------------------------------------------------------------------------
module tcp_retransmit_timewait_timer_table #(
	parameter int SLOTS = tcprt_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tcprt_chan_if.sink  req,
	tcprt_chan_if.source evt,
	tcprt_chan_if.sink  cfg
);
	import tcprt_pkg::*;

	localparam int SW = $clog2(SLOTS);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_EVAL  = 6'b000100,
		ST_SHIFT = 6'b001000,
		ST_EMIT  = 6'b010000,
		ST_FLUSH = 6'b100000
	} state_t;

	state_t      state_q;
	logic [SW-1:0] idx_q;
	evt_t        res_q;
	evt_t        pend_q;
	logic        pend_vld_q;
	evt_t        out_q;
	logic        out_vld_q;

	cfg_regs_t   cfg_q;
	tbl_ctl_t    ctl;
	entry_t      ent_wr;
	entry_t      ent_rd;
	logic [15:0] win_wr;
	logic [15:0] win_rd;
	logic        act_rd;
	logic [SW-1:0] wr_addr;
	logic [SW-1:0] slot_idx;

	alu_mode_t   alu_mode;
	logic [31:0] alu_a;
	logic [31:0] alu_b;
	logic [31:0] alu_res;
	logic        alu_gt;

	logic        acc;
	logic        slot_ok;
	logic        idx_last;
	logic        out_free;
	logic        out_load;
	logic        at_limit;
	state_t      adv_state;

	tcprt_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_q)
	);

	tcprt_table #(
		.SLOTS (SLOTS),
		.SW    (SW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (idx_q),
		.wr_addr (wr_addr),
		.ctl     (ctl),
		.ent_wr  (ent_wr),
		.win_wr  (win_wr),
		.ent_rd  (ent_rd),
		.win_rd  (win_rd),
		.act_rd  (act_rd)
	);

	tcprt_alu u_alu (
		.mode (alu_mode),
		.a    (alu_a),
		.b    (alu_b),
		.res  (alu_res),
		.gt   (alu_gt)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign slot_ok   = 32'(req.data.slot) < SLOTS;
	assign slot_idx  = SW'(req.data.slot);
	assign idx_last  = (idx_q == SW'(SLOTS - 1));
	assign out_free  = !out_vld_q || evt.ready;
	assign out_load  = pend_vld_q && out_free && (state_q == ST_EMIT || state_q == ST_FLUSH);
	assign at_limit  = ent_rd.retry >= cfg_q.retry_limit;
	assign adv_state = idx_last ? ST_FLUSH : ST_READ;

	assign evt.valid = out_vld_q;
	assign evt.data  = out_q;

	always_comb begin
		if (state_q == ST_SHIFT) begin
			alu_mode = ALU_SHL;
			alu_a    = {6'd0, cfg_q.retrans_base};
			alu_b    = {28'd0, ent_rd.retry};
		end else begin
			alu_mode = ALU_SUB;
			alu_a    = ent_rd.remaining;
			alu_b    = {8'd0, cfg_q.tick_interval};
		end
	end

	always_comb begin
		ctl     = '0;
		wr_addr = idx_q;
		ent_wr  = '0;
		win_wr  = 16'd1;
		case (state_q)
			ST_IDLE: begin
				wr_addr = slot_idx;
				if (acc && slot_ok) begin
					case (req.data.operation)
						OP_ARM_TW: begin
							ctl.ent_we  = 1'b1;
							ctl.act_set = 1'b1;
							ent_wr      = '{KIND_TW, 4'd0, {6'd0, cfg_q.timewait_time}};
						end
						OP_ARM_RT: begin
							ctl.ent_we  = 1'b1;
							ctl.act_set = 1'b1;
							ent_wr      = '{KIND_RT, 4'd1, {6'd0, cfg_q.retrans_base}};
						end
						OP_CANCEL: ctl.act_clr = 1'b1;
						OP_WINDOW: begin
							ctl.win_we = 1'b1;
							win_wr     = req.data.window;
						end
						default: ;
					endcase
				end
			end
			ST_EVAL: begin
				if (alu_gt) begin
					ctl.ent_we = 1'b1;
					ent_wr     = '{ent_rd.kind, ent_rd.retry, alu_res};
				end else if (ent_rd.kind == KIND_TW || at_limit) begin
					ctl.act_clr = 1'b1;
				end
			end
			ST_SHIFT: begin
				ctl.ent_we = 1'b1;
				ctl.win_we = 1'b1;
				ent_wr     = '{KIND_RT, ent_rd.retry + 4'd1, alu_res};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_EVAL: begin
				res_q <= '{4'(idx_q), (ent_rd.kind == KIND_TW) ? EV_CLOSE : EV_RESET,
					ent_rd.retry, 32'd0, 15'd0, 1'b0};
			end
			ST_SHIFT: begin
				res_q <= '{4'(idx_q), EV_RESEND, ent_rd.retry + 4'd1, alu_res,
					win_rd[15:1], 1'b0};
			end
			default: ;
		endcase
		if (state_q == ST_EMIT && (!pend_vld_q || out_free)) begin
			pend_q <= res_q;
		end
		if (out_load) begin
			out_q <= (state_q == ST_FLUSH) ? evt_t'({pend_q[$bits(evt_t)-1:1], 1'b1})
				: pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (evt.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc && req.data.operation == OP_TICK) begin
						idx_q   <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (act_rd) begin
						state_q <= ST_EVAL;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= adv_state;
					end
				end
				ST_EVAL: begin
					if (alu_gt) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= adv_state;
					end else if (ent_rd.kind == KIND_TW || at_limit) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (!pend_vld_q || out_free) begin
						pend_vld_q <= 1'b1;
						idx_q      <= idx_q + 1'b1;
						state_q    <= adv_state;
					end
				end
				ST_FLUSH: begin
					if (!pend_vld_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !pend_vld_q)
		else $error("held result left over while idle");

	a_tick_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.data.operation == OP_TICK |=> state_q == ST_READ && idx_q == '0)
		else $error("tick did not start slot walk");

	a_shift_only_resend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT |-> ent_rd.kind == KIND_RT && !at_limit)
		else $error("backoff taken for non-resend expiry");
`endif
endmodule
